FILE: sv/iom_pkg.sv
// ----------------------------------------------------------------------------
// iom_pkg
// Shared types, codes and the interval append function of the interval
// overlay merge block.
// ----------------------------------------------------------------------------
package iom_pkg;

	localparam int POS_BITS  = 24;
	localparam int SEED_BITS = 16;

	// Item kinds carried in the func field.
	localparam logic [1:0] FN_INSERT   = 2'd0;
	localparam logic [1:0] FN_BOUNDARY = 2'd1;
	localparam logic [1:0] FN_END      = 2'd2;

	typedef enum logic [1:0] {
		PH_START    = 2'd0,
		PH_INSERT   = 2'd1,
		PH_BOUNDARY = 2'd2
	} phase_t;

	typedef logic [POS_BITS-1:0] pos_t;
	typedef logic [POS_BITS:0]   pos_ext_t;
	typedef logic [SEED_BITS-1:0] seed_t;

	typedef struct packed {
		logic [1:0] func;
		pos_t       start_pos;
		pos_t       span;
		seed_t      seed_tag;
	} item_t;

	typedef struct packed {
		pos_t  out_start;
		pos_t  out_span;
		seed_t out_seed;
		logic  row_last;
	} res_t;

	typedef struct packed {
		logic  valid;
		pos_t  start;
		pos_t  span;
		seed_t seed;
	} ival_t;

	typedef struct packed {
		phase_t   phase;
		ival_t    held;
		pos_ext_t last_ins_end;
		logic     last_ins_valid;
		ival_t    pend;
	} state_t;

	// Up to two results of one item, packed from entry zero upward.
	typedef struct packed {
		logic [1:0]     cnt;
		res_t [1:0]     item;
	} res_pair_t;

	typedef struct packed {
		ival_t pend;
		logic  emit;
		res_t  res;
	} app_t;

	// Joins an interval to the pending one when it has the same seed and
	// starts where the pending one ends; otherwise the pending interval is
	// released and the new one takes its place.
	function automatic app_t append_iv(ival_t p, pos_t s, pos_t len, seed_t seed);
		app_t     a;
		pos_ext_t pend_end;
		pos_ext_t sum;
		logic     joinable;
		pend_end = {1'b0, p.start} + {1'b0, p.span};
		sum      = {1'b0, p.span} + {1'b0, len};
		joinable = p.valid && (p.seed == seed) && (pend_end == {1'b0, s});
		a.res    = '{out_start: p.start, out_span: p.span, out_seed: p.seed,
			row_last: 1'b0};
		if (joinable) begin
			a.emit = 1'b0;
			a.pend = p;
			a.pend.span = sum[POS_BITS] ? '1 : sum[POS_BITS-1:0];
		end else begin
			a.emit = p.valid;
			a.pend = '{valid: 1'b1, start: s, span: len, seed: seed};
		end
		return a;
	endfunction

endpackage

FILE: sv/iom_step.sv
// ----------------------------------------------------------------------------
// iom_step
// Next-state and result logic for one registered input item.
// ----------------------------------------------------------------------------
module iom_step (
	input  iom_pkg::state_t    cur,
	input  iom_pkg::item_t     it,
	output iom_pkg::state_t    nxt,
	output iom_pkg::res_pair_t pair
);

	iom_pkg::app_t     a1;
	iom_pkg::app_t     a2;
	iom_pkg::pos_ext_t e;
	iom_pkg::pos_ext_t hend;
	iom_pkg::res_t     d0;
	iom_pkg::res_t     d1;
	logic              e0;
	logic              e1;

	assign e    = {1'b0, it.start_pos} + {1'b0, it.span};
	assign hend = {1'b0, cur.held.start} + {1'b0, cur.held.span};

	always_comb begin
		nxt = cur;
		a1  = '{pend: cur.pend, emit: 1'b0, res: '0};
		a2  = '{pend: cur.pend, emit: 1'b0, res: '0};
		e0  = 1'b0;
		e1  = 1'b0;
		d0  = '0;
		d1  = '0;
		unique case (it.func)
			iom_pkg::FN_END: begin
				if (cur.phase != iom_pkg::PH_START) begin
					if (cur.held.valid) begin
						a1 = iom_pkg::append_iv(cur.pend, cur.held.start,
							cur.held.span, cur.held.seed);
					end
					e0 = a1.emit;
					d0 = a1.res;
					e1 = a1.pend.valid;
					d1 = '{out_start: a1.pend.start, out_span: a1.pend.span,
						out_seed: a1.pend.seed, row_last: 1'b1};
				end
				nxt = '0;
			end
			iom_pkg::FN_BOUNDARY: begin
				if (it.span != '0) begin
					if (cur.held.valid) begin
						a1 = iom_pkg::append_iv(cur.pend, cur.held.start,
							cur.held.span, cur.held.seed);
					end
					e0 = a1.emit;
					d0 = a1.res;
					nxt.pend = a1.pend;
					nxt.held = '{valid: 1'b1, start: it.start_pos, span: it.span,
						seed: it.seed_tag};
					// Cut the new boundary against the end of the last insert.
					if (cur.last_ins_valid && ({1'b0, it.start_pos} < cur.last_ins_end)) begin
						if (e > cur.last_ins_end) begin
							nxt.held.span  = iom_pkg::pos_t'(e - cur.last_ins_end);
							nxt.held.start = cur.last_ins_end[iom_pkg::POS_BITS-1:0];
						end else begin
							nxt.held = '0;
						end
					end
					nxt.phase = iom_pkg::PH_BOUNDARY;
				end
			end
			iom_pkg::FN_INSERT: begin
				if (it.span != '0) begin
					if (cur.held.valid) begin
						if ({1'b0, it.start_pos} < hend) begin
							// The part of the boundary before the insert, if any.
							if (it.start_pos > cur.held.start) begin
								a1 = iom_pkg::append_iv(cur.pend, cur.held.start,
									it.start_pos - cur.held.start, cur.held.seed);
							end
						end else begin
							a1 = iom_pkg::append_iv(cur.pend, cur.held.start,
								cur.held.span, cur.held.seed);
						end
						if (e < hend) begin
							nxt.held.span  = iom_pkg::pos_t'(hend - e);
							nxt.held.start = e[iom_pkg::POS_BITS-1:0];
						end else begin
							nxt.held = '0;
						end
					end
					a2 = iom_pkg::append_iv(a1.pend, it.start_pos, it.span, it.seed_tag);
					e0 = a1.emit;
					d0 = a1.res;
					e1 = a2.emit;
					d1 = a2.res;
					nxt.pend           = a2.pend;
					nxt.last_ins_end   = e;
					nxt.last_ins_valid = 1'b1;
					nxt.phase          = iom_pkg::PH_INSERT;
				end
			end
			default: begin
			end
		endcase

		// Pack the results from entry zero upward.
		if (e0) begin
			pair.item[0] = d0;
			pair.item[1] = d1;
			pair.cnt     = e1 ? 2'd2 : 2'd1;
		end else begin
			pair.item[0] = d1;
			pair.item[1] = '0;
			pair.cnt     = e1 ? 2'd1 : 2'd0;
		end
	end

endmodule

FILE: sv/iom_outq.sv
// ----------------------------------------------------------------------------
// iom_outq
// Small result queue: takes up to two results a cycle, releases one while the receiver does not stall.
// ----------------------------------------------------------------------------
module iom_outq #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  iom_pkg::res_pair_t push,
	output logic               room2,
	output logic               res_valid,
	input  logic               res_stall,
	output iom_pkg::res_t      res
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	iom_pkg::res_t  entry_q [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	logic [AW-1:0]  wr1;
	logic           pop;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr1       = ptr_inc(wr_q);
	assign res_valid = (cnt_q != '0);
	assign pop       = res_valid && !res_stall;
	assign res       = entry_q[rd_q];
	assign room2     = (cnt_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			entry_q[wr_q] <= push.item[0];
		end
		if (push.cnt == 2'd2) begin
			entry_q[wr1] <= push.item[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.cnt == 2'd1) begin
				wr_q <= wr1;
			end else if (push.cnt == 2'd2) begin
				wr_q <= ptr_inc(wr1);
			end
			if (pop) begin
				rd_q <= ptr_inc(rd_q);
			end
			cnt_q <= cnt_q + CW'(push.cnt) - CW'(pop);
		end
	end

endmodule

FILE: sv/interval_overlay_merge_core.sv
// ----------------------------------------------------------------------------
// interval_overlay_merge_core
// Overlays insert intervals on boundary intervals of one row and coalesces
// touching output intervals of the same seed.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the item channel (item_valid, item_stall, item) as insert
// intervals, boundary intervals and one end-of-row marker per row. Results
// leave on the res channel (res_valid, res_stall, res); the last result of a
// row carries row_last. A transfer happens at a rising edge where valid is
// high and stall is low.
// An accepted item is captured in an input register and is worked on once
// the short result queue has room for two results; the work writes its zero,
// one or two results into that queue. Results go through the input register
// and the result queue before they are offered.
// A new item is taken every cycle while the queue has room for two results.
// The single result port sets the sustained rate: an item yielding two
// results needs two transfers on the result port.
// When the receiver stalls, the queue fills and item_stall rises; nothing is
// dropped. Reset empties the input register and the queue and returns the
// row state to its start: nothing held, nothing pending, no insert seen.
// ----------------------------------------------------------------------------
module interval_overlay_merge_core #(
	parameter int OUTQ_DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  iom_pkg::item_t item,
	output logic           res_valid,
	input  logic           res_stall,
	output iom_pkg::res_t  res
);

	// Input stage.
	logic               vld_s1;
	iom_pkg::item_t     item_s1;

	// Row state: held boundary, last insert end and pending output interval.
	iom_pkg::state_t    state_q;
	iom_pkg::state_t    nxt;

	iom_pkg::res_pair_t pair;
	iom_pkg::res_pair_t push;
	logic               room2;
	logic               proc;
	logic               accept;

	// The registered item is worked on once the queue can take two results.
	assign proc       = vld_s1 && room2;
	assign item_stall = vld_s1 && !room2;
	assign accept     = item_valid && !item_stall;
	assign push       = proc ? pair : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (proc) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (proc) begin
			state_q <= nxt;
		end
	end

	iom_step u_step (
		.cur  (state_q),
		.it   (item_s1),
		.nxt  (nxt),
		.pair (pair)
	);

	iom_outq #(
		.DEPTH (OUTQ_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (room2),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// An end marker always leaves the row state at its start.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		proc && (item_s1.func == iom_pkg::FN_END)
		|=> (state_q.phase == iom_pkg::PH_START) && !state_q.pend.valid
			&& !state_q.held.valid)
		else $error("row state not cleared after end marker");

	// Something pending means the row has started.
	a_pend_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pend.valid |-> (state_q.phase != iom_pkg::PH_START))
		else $error("pending interval outside a row");

	// A held boundary piece only exists inside a row.
	a_held_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.held.valid |-> (state_q.phase != iom_pkg::PH_START))
		else $error("held boundary outside a row");

	// Back-pressure on items only comes from results waiting in the queue.
	a_stall_queue: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> res_valid)
		else $error("item stall with an empty result queue");

endmodule
